// ----- design/all_pairs_distance_stats_macros.svh -----
// ----------------------------------------------------------------------------
// All-pairs distance statistics: assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef ALL_PAIRS_DISTANCE_STATS_MACROS_SVH
`define ALL_PAIRS_DISTANCE_STATS_MACROS_SVH

// Same-cycle implication, reset disables the check.
`define APDS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset disables the check.
`define APDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/apds_pkg.sv -----
// ----------------------------------------------------------------------------
// apds_pkg
// Field widths, saturation limits and status codes of the distance block.
// ----------------------------------------------------------------------------
package apds_pkg;

	localparam int COORD_IN_W = 24;
	localparam int DIST_W     = 33;
	localparam int SUM_W      = 48;
	localparam int COUNT_W    = 15;
	localparam int STATUS_W   = 2;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DROP  = 2'd2;

endpackage

// ----- design/apds_if.sv -----
// ----------------------------------------------------------------------------
// apds_if
// Valid/ready channels for point beats and result beats.
// ----------------------------------------------------------------------------
interface apds_in_if;
	logic                              valid;
	logic                              ready;
	logic [apds_pkg::COORD_IN_W-1:0]   point_east;
	logic [apds_pkg::COORD_IN_W-1:0]   point_north;
	logic                              last_point;

	modport source (output valid, output point_east, output point_north,
		output last_point, input ready);
	modport sink (input valid, input point_east, input point_north,
		input last_point, output ready);
endinterface

interface apds_out_if;
	logic                              valid;
	logic                              ready;
	logic [apds_pkg::DIST_W-1:0]       shortest_dist;
	logic [apds_pkg::DIST_W-1:0]       longest_dist;
	logic [apds_pkg::DIST_W-1:0]       mean_dist;
	logic [apds_pkg::COUNT_W-1:0]      pair_count;
	logic [apds_pkg::STATUS_W-1:0]     status;

	modport source (output valid, output shortest_dist, output longest_dist,
		output mean_dist, output pair_count, output status, input ready);
	modport sink (input valid, input shortest_dist, input longest_dist,
		input mean_dist, input pair_count, input status, output ready);
endinterface

// ----- design/apds_store.sv -----
// ----------------------------------------------------------------------------
// apds_store
// Point memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module apds_store #(
	parameter int DEPTH = 256,
	parameter int DW    = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/apds_sqrt.sv -----
// ----------------------------------------------------------------------------
// apds_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module apds_sqrt #(
	parameter int RB = 33
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [2*RB-1:0] radicand,
	output logic            done,
	output logic [RB-1:0]   root
);

	localparam int CW = $clog2(RB + 1);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [2*RB-1:0] x_q;
	logic [RB:0]     rem_q;
	logic [RB-1:0]   root_q;

	logic [RB+2:0]   rem_sh;
	logic [RB+2:0]   rem_sub;
	logic [RB+2:0]   trial;
	logic            take;

	always_comb begin
		rem_sh  = {rem_q, x_q[2*RB-1 -: 2]};
		trial   = {1'b0, root_q, 2'b01};
		rem_sub = rem_sh - trial;
		take    = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(RB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q <= x_q << 2;
			if (take) begin
				rem_q  <= rem_sub[RB:0];
				root_q <= {root_q[RB-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[RB:0];
				root_q <= {root_q[RB-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ----- design/apds_div.sv -----
// ----------------------------------------------------------------------------
// apds_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module apds_div #(
	parameter int NW = 48,
	parameter int DW = 18
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] q_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;

	logic [DW:0]   rem_sh;
	logic [DW:0]   rem_sub;
	logic          take;

	always_comb begin
		rem_sh  = {rem_q, q_q[NW-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		take    = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			q_q   <= {q_q[NW-2:0], take};
			rem_q <= take ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = q_q;

endmodule

// ----- design/all_pairs_distance_stats.sv -----
// ----------------------------------------------------------------------------
// all_pairs_distance_stats
// Shortest, longest and mean Euclidean distance over all point pairs.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                            per set
//  in_ch     in   point_east, point_north, last_point                 n beats
//  out_ch    out  shortest_dist, longest_dist, mean_dist, pair_count, 1 beat
//                 status
//
//  Point beats that are not last load back to back.
//  The last beat starts the pair walk unless the set has under two points:
//  per pair a difference, square, sum and bit-serial square root, a read per
//  new first point, then mean division. The square root unit sets the rate.
//  Reset clears the set; the point memory needs no clearing.
//  A result that waits on out_ch.ready holds loading only once the following
//  set's walk is done and that set waits to deliver.
// ----------------------------------------------------------------------------
module all_pairs_distance_stats #(
	parameter int MAX_POINTS = 256,
	parameter int COORD_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	apds_in_if.sink           in_ch,
	apds_out_if.source        out_ch
);

	localparam int AW    = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int PW    = 2 * CNT_W;
	localparam int CW    = COORD_BITS;
	localparam int DW    = 2 * CW;
	localparam int RB    = COORD_BITS + 9;
	localparam int DIST_W = apds_pkg::DIST_W;
	localparam int SUM_W  = apds_pkg::SUM_W;

	localparam logic [3:0] S_LOAD = 4'd0;
	localparam logic [3:0] S_RDI  = 4'd1;
	localparam logic [3:0] S_LATI = 4'd2;
	localparam logic [3:0] S_DIFF = 4'd3;
	localparam logic [3:0] S_MUL  = 4'd4;
	localparam logic [3:0] S_ADD  = 4'd5;
	localparam logic [3:0] S_SQRT = 4'd6;
	localparam logic [3:0] S_MEAN = 4'd7;
	localparam logic [3:0] S_DIVW = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	logic [3:0]        state_q;
	logic [CNT_W-1:0]  held_q;
	logic              ovf_q;
	logic              short_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  j_q;
	logic [PW-1:0]     pairs_q;
	logic [DIST_W-1:0] min_q;
	logic [DIST_W-1:0] max_q;
	logic [SUM_W-1:0]  sum_q;
	logic [DW-1:0]     pi_q;
	logic [CW-1:0]     dx_q;
	logic [CW-1:0]     dy_q;
	logic [DW-1:0]     dxx_q;
	logic [DW-1:0]     dyy_q;

	logic              out_valid_q;
	logic [DIST_W-1:0] out_min_q;
	logic [DIST_W-1:0] out_max_q;
	logic [DIST_W-1:0] out_mean_q;
	logic [apds_pkg::COUNT_W-1:0]  out_cnt_q;
	logic [apds_pkg::STATUS_W-1:0] out_st_q;

	logic              accept;
	logic              full;
	logic [CNT_W-1:0]  cnt_next;
	logic [CW-1:0]     e_in;
	logic [CW-1:0]     n_in;
	logic              re;
	logic [AW-1:0]     raddr;
	logic [DW-1:0]     rdata;
	logic              more_j;
	logic              more_i;
	logic              sq_start;
	logic [2*RB-1:0]   radicand;
	logic              sq_done;
	logic [RB-1:0]     root;
	logic [DIST_W-1:0] d_sat;
	logic [SUM_W:0]    sum_add;
	logic              div_start;
	logic              div_done;
	logic [SUM_W-1:0]  quot;
	logic              slot_free;
	logic [CW-1:0]     pe;
	logic [CW-1:0]     pn;
	logic [CW-1:0]     qe;
	logic [CW-1:0]     qn;

	assign e_in     = CW'(in_ch.point_east);
	assign n_in     = CW'(in_ch.point_north);
	assign in_ch.ready = (state_q == S_LOAD);
	assign accept   = in_ch.valid & in_ch.ready;
	assign full     = (held_q == CNT_W'(MAX_POINTS));
	assign cnt_next = full ? held_q : held_q + 1'b1;
	assign more_j   = (CNT_W+1)'(j_q) + 1'b1 < (CNT_W+1)'(cnt_q);
	assign more_i   = (CNT_W+1)'(i_q) + 2'd2 < (CNT_W+1)'(cnt_q);
	assign slot_free = !out_valid_q || out_ch.ready;

	always_comb begin
		re    = 1'b0;
		raddr = i_q[AW-1:0];
		case (state_q)
			S_RDI: begin
				re = 1'b1;
			end
			S_LATI: begin
				re    = 1'b1;
				raddr = j_q[AW-1:0];
			end
			S_SQRT: begin
				re    = sq_done && more_j;
				raddr = AW'(j_q + 1'b1);
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	apds_store #(.DEPTH(MAX_POINTS), .DW(DW)) u_store (
		.clk   (clk),
		.we    (accept && !full),
		.waddr (held_q[AW-1:0]),
		.wdata ({e_in, n_in}),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign pe = pi_q[DW-1:CW];
	assign pn = pi_q[CW-1:0];
	assign qe = rdata[DW-1:CW];
	assign qn = rdata[CW-1:0];

	assign sq_start = (state_q == S_ADD);
	assign radicand = (2*RB)'((DW+1)'(dxx_q) + (DW+1)'(dyy_q)) << 16;

	apds_sqrt #(.RB(RB)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (radicand),
		.done     (sq_done),
		.root     (root)
	);

	// clip roots that do not fit the distance field
	always_comb begin
		if (64'(root) > 64'(apds_pkg::DIST_MAX)) begin
			d_sat = apds_pkg::DIST_MAX;
		end else begin
			d_sat = DIST_W'(root);
		end
		sum_add = (SUM_W+1)'(sum_q) + (SUM_W+1)'(d_sat);
	end

	assign div_start = (state_q == S_MEAN);

	apds_div #(.NW(SUM_W), .DW(PW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (pairs_q),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			held_q      <= '0;
			ovf_q       <= 1'b0;
			short_q     <= 1'b0;
			min_q       <= apds_pkg::DIST_MAX;
			max_q       <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new beat loaded in the done state replaces the one leaving
			if (out_valid_q && out_ch.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							held_q <= held_q + 1'b1;
						end
						if (in_ch.last_point) begin
							short_q <= (cnt_next < CNT_W'(2));
							state_q <= (cnt_next < CNT_W'(2)) ? S_DONE : S_RDI;
						end
					end
				end
				S_RDI: begin
					state_q <= S_LATI;
				end
				S_LATI: begin
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (sq_done) begin
						sum_q <= sum_add[SUM_W] ? apds_pkg::SUM_MAX : sum_add[SUM_W-1:0];
						if (d_sat > max_q) begin
							max_q <= d_sat;
						end
						if (d_sat < min_q) begin
							min_q <= d_sat;
						end
						if (more_j) begin
							state_q <= S_DIFF;
						end else if (more_i) begin
							state_q <= S_RDI;
						end else begin
							state_q <= S_MEAN;
						end
					end
				end
				S_MEAN: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hold until the result register is free, then clear the set
					if (slot_free) begin
						out_valid_q <= 1'b1;
						held_q      <= '0;
						ovf_q       <= 1'b0;
						min_q       <= apds_pkg::DIST_MAX;
						max_q       <= '0;
						sum_q       <= '0;
						state_q     <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// pair walk indexes and datapath
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD && accept && in_ch.last_point) begin
			cnt_q   <= cnt_next;
			pairs_q <= PW'((PW'(cnt_next) * PW'(cnt_next - 1'b1)) >> 1);
			i_q     <= '0;
			j_q     <= CNT_W'(1);
		end else if (state_q == S_SQRT && sq_done) begin
			if (more_j) begin
				j_q <= j_q + 1'b1;
			end else if (more_i) begin
				i_q <= i_q + 1'b1;
				j_q <= i_q + 2'd2;
			end
		end
		if (state_q == S_LATI) begin
			pi_q <= rdata;
		end
		if (state_q == S_DIFF) begin
			dx_q <= (pe > qe) ? pe - qe : qe - pe;
			dy_q <= (pn > qn) ? pn - qn : qn - pn;
		end
		if (state_q == S_MUL) begin
			dxx_q <= DW'(dx_q) * DW'(dx_q);
			dyy_q <= DW'(dy_q) * DW'(dy_q);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && slot_free) begin
			if (short_q) begin
				out_min_q  <= '0;
				out_max_q  <= '0;
				out_mean_q <= '0;
				out_cnt_q  <= '0;
				out_st_q   <= apds_pkg::ST_SHORT;
			end else begin
				out_min_q  <= min_q;
				out_max_q  <= max_q;
				out_mean_q <= DIST_W'(quot);
				out_cnt_q  <= apds_pkg::COUNT_W'(pairs_q);
				out_st_q   <= ovf_q ? apds_pkg::ST_DROP : apds_pkg::ST_OK;
			end
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.shortest_dist = out_min_q;
	assign out_ch.longest_dist  = out_max_q;
	assign out_ch.mean_dist     = out_mean_q;
	assign out_ch.pair_count    = out_cnt_q;
	assign out_ch.status        = out_st_q;

endmodule

// ----- design/apds_checker.sv -----
// ----------------------------------------------------------------------------
// apds_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "all_pairs_distance_stats_macros.svh"

module apds_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [apds_pkg::DIST_W-1:0]     shortest_dist,
	input logic [apds_pkg::DIST_W-1:0]     longest_dist,
	input logic [apds_pkg::DIST_W-1:0]     mean_dist,
	input logic [apds_pkg::COUNT_W-1:0]    pair_count,
	input logic [apds_pkg::STATUS_W-1:0]   status
);

	logic stall;
	logic short_beat;
	logic full_beat;
	logic zeros;
	logic ordered;
	logic [3*apds_pkg::DIST_W+apds_pkg::COUNT_W+apds_pkg::STATUS_W-1:0] beat;

	assign stall      = out_valid && !out_ready;
	assign short_beat = out_valid && status == apds_pkg::ST_SHORT;
	assign full_beat  = out_valid && status != apds_pkg::ST_SHORT;
	assign zeros      = shortest_dist == '0 && longest_dist == '0 && mean_dist == '0
		&& pair_count == '0;
	assign ordered    = shortest_dist <= mean_dist && mean_dist <= longest_dist;
	assign beat       = {shortest_dist, longest_dist, mean_dist, pair_count, status};

	`APDS_ASSERT_NEXT(a_out_hold, clk, arst_n, stall, out_valid, "beat dropped while stalled")
	`APDS_ASSERT_NEXT(a_out_stable, clk, arst_n, stall, $stable(beat), "beat changed while stalled")
	`APDS_ASSERT_NOW(a_short_zero, clk, arst_n, short_beat, zeros, "short set must report zeros")
	`APDS_ASSERT_NOW(a_mean_bounds, clk, arst_n, full_beat, ordered, "mean outside bounds")

endmodule

bind all_pairs_distance_stats apds_checker u_apds_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.shortest_dist (out_ch.shortest_dist),
	.longest_dist  (out_ch.longest_dist),
	.mean_dist     (out_ch.mean_dist),
	.pair_count    (out_ch.pair_count),
	.status        (out_ch.status)
);

// ----- test/tb_all_pairs_distance_stats.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_all_pairs_distance_stats
// Loads point sets through the input channel and checks each set's shortest,
// longest and mean pair distance, pair count and status against a predictor.
// ----------------------------------------------------------------------------
module tb_all_pairs_distance_stats;

	localparam int STORE_DEPTH = 256;
	localparam int CBITS       = 24;
	localparam int HOLD_CYCLES = 20000;

	// coordinate spreads
	localparam int SPREAD_TINY   = 0;
	localparam int SPREAD_WINDOW = 1;
	localparam int SPREAD_FULL   = 2;

	typedef struct packed {
		logic [apds_pkg::DIST_W-1:0]   shortest;
		logic [apds_pkg::DIST_W-1:0]   longest;
		logic [apds_pkg::DIST_W-1:0]   mean;
		logic [apds_pkg::COUNT_W-1:0]  pairs;
		logic [apds_pkg::STATUS_W-1:0] status;
	} set_stats_t;

	logic clk;
	logic arst_n;

	apds_in_if  in_ch ();
	apds_out_if out_ch ();

	all_pairs_distance_stats #(
		.MAX_POINTS(STORE_DEPTH),
		.COORD_BITS(CBITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// predictor state for the set being loaded
	logic [CBITS-1:0] set_east[$];
	logic [CBITS-1:0] set_north[$];
	logic             set_dropped;
	set_stats_t       stats_due[$];

	int   send_idle_pct;
	int   recv_idle_pct;
	logic recv_hold;
	event hold_go;
	int   error_count;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#200_000_000;
		$display("all_pairs_distance_stats: mismatch");
		$finish;
	end

	function automatic logic [40:0] fixed_root(input logic [63:0] sq);
		logic [127:0] target;
		logic [127:0] trial;
		logic [40:0]  root;
		target = {64'd0, sq} << 16;
		root = '0;
		for (int b = 40; b >= 0; b--) begin
			trial = {87'd0, root} | (128'd1 << b);
			if (trial * trial <= target) begin
				root = trial[40:0];
			end
		end
		return root;
	endfunction

	function automatic set_stats_t measure_set();
		set_stats_t  res;
		logic [63:0] dx, dy;
		logic [40:0] d;
		logic [47:0] total;
		logic [63:0] wide_sum;
		logic [apds_pkg::DIST_W-1:0] lo, hi, dq;
		longint      cnt, npairs;
		cnt = set_east.size();
		npairs = cnt * (cnt > 0 ? cnt - 1 : 0) / 2;
		res = '0;
		if (cnt < 2) begin
			res.status = apds_pkg::ST_SHORT;
			return res;
		end
		lo = apds_pkg::DIST_MAX;
		hi = '0;
		total = '0;
		for (int i = 0; i + 1 < cnt; i++) begin
			for (int j = i + 1; j < cnt; j++) begin
				dx = (set_east[i] > set_east[j]) ? set_east[i] - set_east[j]
					: set_east[j] - set_east[i];
				dy = (set_north[i] > set_north[j]) ? set_north[i] - set_north[j]
					: set_north[j] - set_north[i];
				d = fixed_root(dx * dx + dy * dy);
				dq = (d > apds_pkg::DIST_MAX) ? apds_pkg::DIST_MAX : d[apds_pkg::DIST_W-1:0];
				wide_sum = {16'd0, total} + dq;
				total = (wide_sum > apds_pkg::SUM_MAX) ? apds_pkg::SUM_MAX : wide_sum[47:0];
				if (dq > hi) begin
					hi = dq;
				end
				if (dq < lo) begin
					lo = dq;
				end
			end
		end
		res.shortest = lo;
		res.longest = hi;
		res.mean = apds_pkg::DIST_W'(total / npairs);
		res.pairs = npairs[apds_pkg::COUNT_W-1:0];
		res.status = set_dropped ? apds_pkg::ST_DROP : apds_pkg::ST_OK;
		return res;
	endfunction

	function automatic void predict_beat(input logic [apds_pkg::COORD_IN_W-1:0] e,
		input logic [apds_pkg::COORD_IN_W-1:0] n, input logic last);
		if (set_east.size() < STORE_DEPTH) begin
			set_east = {set_east, e[CBITS-1:0]};
			set_north = {set_north, n[CBITS-1:0]};
		end else begin
			set_dropped = 1'b1;
		end
		if (last) begin
			stats_due = {stats_due, measure_set()};
			set_east.delete();
			set_north.delete();
			set_dropped = 1'b0;
		end
	endfunction

	task automatic send_point(input logic [apds_pkg::COORD_IN_W-1:0] e,
		input logic [apds_pkg::COORD_IN_W-1:0] n, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.point_east  <= e;
		in_ch.point_north <= n;
		in_ch.last_point  <= last;
		do begin
			@(posedge clk);
		end while (!in_ch.ready);
		predict_beat(e, n, last);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("%0t: %s got %0d expected %0d", $time, what, got, want);
		error_count++;
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (stats_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// random coordinate, sometimes confined to a narrow window
	function automatic logic [apds_pkg::COORD_IN_W-1:0] pick_coord(input int spread);
		case (spread)
			SPREAD_TINY: return apds_pkg::COORD_IN_W'($urandom_range(15));
			SPREAD_WINDOW: return apds_pkg::COORD_IN_W'(24'h7F_FF00 + $urandom_range(255));
			default: return apds_pkg::COORD_IN_W'($urandom);
		endcase
	endfunction

	task automatic send_set(input int npts, input int spread);
		for (int k = 0; k < npts; k++) begin
			send_point(pick_coord(spread), pick_coord(spread), k == npts - 1);
		end
	endtask

	// long receiver hold-off, counted here
	initial begin
		recv_hold = 1'b0;
		forever begin
			@(hold_go);
			recv_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			recv_hold <= 1'b0;
		end
	end

	// receiver: random stalls, plus the hold-off when requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (recv_hold) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		set_stats_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (stats_due.size() == 0) begin
				report_mismatch("unexpected result beat", 0, 0);
			end else begin
				want = stats_due.pop_front();
				if (out_ch.shortest_dist !== want.shortest)
					report_mismatch("shortest_dist", out_ch.shortest_dist, want.shortest);
				if (out_ch.longest_dist !== want.longest)
					report_mismatch("longest_dist", out_ch.longest_dist, want.longest);
				if (out_ch.mean_dist !== want.mean)
					report_mismatch("mean_dist", out_ch.mean_dist, want.mean);
				if (out_ch.pair_count !== want.pairs)
					report_mismatch("pair_count", out_ch.pair_count, want.pairs);
				if (out_ch.status !== want.status)
					report_mismatch("status", out_ch.status, want.status);
			end
		end
	end

	task automatic test_directed();
		send_point(24'd5, 24'd9, 1'b1);
		send_point(24'd0, 24'd0, 1'b0);
		send_point(24'hFF_FFFF, 24'hFF_FFFF, 1'b1);
		send_point(24'hFF_FFFF, 24'd0, 1'b0);
		send_point(24'd0, 24'hFF_FFFF, 1'b1);
		// identical points give a zero distance
		send_point(24'h12_3456, 24'h65_4321, 1'b0);
		send_point(24'h12_3456, 24'h65_4321, 1'b1);
		// new maximum that is also the first minimum, then shorter and longer pairs
		send_point(24'd0, 24'd0, 1'b0);
		send_point(24'd3, 24'd4, 1'b0);
		send_point(24'd1, 24'd1, 1'b0);
		send_point(24'hAA_AAAA, 24'h55_5555, 1'b1);
		send_point(24'd1, 24'd2, 1'b0);
		send_point(24'd2, 24'd3, 1'b0);
		send_point(24'd7, 24'd7, 1'b1);
	endtask

	// fill the store and push past capacity; the last beat is a dropped point
	task automatic test_overflow();
		recv_idle_pct = 0;
		send_idle_pct = 0;
		send_set(STORE_DEPTH + 3, SPREAD_FULL);
		wait_drained();
	endtask

	task automatic test_backpressure();
		send_set(3, SPREAD_FULL);
		-> hold_go;
		for (int s = 0; s < 8; s++) begin
			send_set(2 + s % 3, SPREAD_FULL);
		end
		// pause until everything is back
		wait_drained();
	endtask

	task automatic test_random(input int beats);
		int sent, npts, spread;
		sent = 0;
		while (sent < beats) begin
			case ($urandom_range(19))
				0: npts = 1;
				1: npts = $urandom_range(20, 40);
				default: npts = $urandom_range(2, 10);
			endcase
			if ($urandom_range(3) == 0) begin
				spread = ($urandom_range(1) == 0) ? SPREAD_TINY : SPREAD_WINDOW;
			end else begin
				spread = SPREAD_FULL;
			end
			send_set(npts, spread);
			sent += npts;
		end
		wait_drained();
	endtask

	initial begin
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.point_east  = '0;
		in_ch.point_north = '0;
		in_ch.last_point  = 1'b0;
		send_idle_pct     = 0;
		recv_idle_pct     = 0;
		error_count       = 0;
		set_dropped       = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 11;
		recv_idle_pct = 86;
		test_directed();
		wait_drained();
		test_backpressure();
		test_random(440);
		send_idle_pct = 86;
		recv_idle_pct = 11;
		test_random(440);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(440);
		test_overflow();

		wait_drained();
		repeat (100) @(posedge clk);
		if (error_count == 0) begin
			$display("all_pairs_distance_stats: match");
		end else begin
			$display("all_pairs_distance_stats: mismatch");
		end
		$finish;
	end

endmodule
